FILE: design/kpt_pkg.sv
// kpt_pkg: shared types and codes for the keyed property table.
// Used by every module of the block but kpt_ram; depends on nothing.

package kpt_pkg;

  localparam int NUM_SLOTS_DEF = 32;

  localparam int KEY_W   = 16;
  localparam int VALUE_W = 64;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  // request codes
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // result codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_ACT,
    ST_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic scan_en;
    logic act;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: design/kpt_ram.sv
// kpt_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package use.

module kpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/kpt_ctrl.sv
// kpt_ctrl: request sequencer for the keyed property table.
// Uses kpt_pkg for state, command and status types.

module kpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  kpt_pkg::dp_status_t dp_st,
  output kpt_pkg::ctrl_cmd_t  cmd
);

  kpt_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      kpt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = kpt_pkg::ST_SCAN;
        end
      end
      kpt_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (dp_st.scan_last) begin
          state_next = kpt_pkg::ST_LAST;
        end
      end
      kpt_pkg::ST_LAST: begin
        state_next = kpt_pkg::ST_ACT;
      end
      kpt_pkg::ST_ACT: begin
        cmd.act    = 1'b1;
        state_next = kpt_pkg::ST_DONE;
      end
      kpt_pkg::ST_DONE: begin
        if (!dp_st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = kpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kpt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/kpt_datapath.sv
// kpt_datapath: request registers, slot scan, valid bits, slot RAMs and result register.
// Uses kpt_pkg and instantiates kpt_ram for keys and values.

module kpt_datapath #(
  parameter int NUM_SLOTS = kpt_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kpt_pkg::ctrl_cmd_t            cmd,
  output kpt_pkg::dp_status_t           dp_st,
  input  logic [kpt_pkg::CMD_W-1:0]     in_cmd,
  input  logic [kpt_pkg::KEY_W-1:0]     in_key,
  input  logic [kpt_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kpt_pkg::STAT_W-1:0]    out_status,
  output logic [kpt_pkg::VALUE_W-1:0]   out_value
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [kpt_pkg::CMD_W-1:0]   req_cmd;
  logic [kpt_pkg::KEY_W-1:0]   req_key;
  logic [kpt_pkg::VALUE_W-1:0] req_value;

  logic [NUM_SLOTS-1:0] valid;
  logic [IDX_W-1:0]     cnt;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 match_found;
  logic [IDX_W-1:0]     match_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;

  logic [kpt_pkg::STAT_W-1:0] res_status;
  logic                       res_get_hit;

  logic [kpt_pkg::KEY_W-1:0]   key_rdata;
  logic [kpt_pkg::VALUE_W-1:0] val_rdata;

  // action decode
  logic                       key_we, val_we, val_re, set_vld, clr_vld;
  logic [IDX_W-1:0]           wr_idx;
  logic [kpt_pkg::STAT_W-1:0] act_status;

  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_re     = 1'b0;
    set_vld    = 1'b0;
    clr_vld    = 1'b0;
    wr_idx     = match_idx;
    act_status = kpt_pkg::STAT_NOT_FOUND;
    case (req_cmd)
      kpt_pkg::CMD_SET: begin
        if (match_found) begin
          val_we     = cmd.act;
          act_status = kpt_pkg::STAT_OK;
        end else if (free_found) begin
          wr_idx     = free_idx;
          key_we     = cmd.act;
          val_we     = cmd.act;
          set_vld    = cmd.act;
          act_status = kpt_pkg::STAT_OK;
        end else begin
          act_status = kpt_pkg::STAT_FULL;
        end
      end
      kpt_pkg::CMD_GET: begin
        if (match_found) begin
          val_re     = cmd.act;
          act_status = kpt_pkg::STAT_OK;
        end
      end
      kpt_pkg::CMD_REMOVE: begin
        if (match_found) begin
          clr_vld    = cmd.act;
          act_status = kpt_pkg::STAT_OK;
        end
      end
      default: begin
        act_status = kpt_pkg::STAT_NOT_FOUND;
      end
    endcase
  end

  assign dp_st.scan_last = (cnt == LAST_IDX);
  assign dp_st.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd   <= in_cmd;
      req_key   <= in_key;
      req_value <= in_value;
    end
    cmp_idx <= cnt;
    if (cmd.act) begin
      res_status  <= act_status;
      res_get_hit <= (req_cmd == kpt_pkg::CMD_GET) && match_found;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_value  <= res_get_hit ? val_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      cnt         <= '0;
      cmp_vld     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      match_idx   <= '0;
      free_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_en;
      if (cmd.load_req) begin
        cnt         <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (cmd.scan_en && !dp_st.scan_last) begin
        cnt <= cnt + 1'b1;
      end
      // compare stage, one slot behind the key RAM address
      if (cmp_vld) begin
        if (valid[cmp_idx] && key_rdata == req_key && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= cmp_idx;
        end
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
      if (set_vld) begin
        valid[wr_idx] <= 1'b1;
      end
      if (clr_vld) begin
        valid[wr_idx] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  kpt_ram #(
    .WIDTH (kpt_pkg::KEY_W),
    .DEPTH (NUM_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_idx),
    .wdata (req_key),
    .re    (cmd.scan_en),
    .raddr (cnt),
    .rdata (key_rdata)
  );

  kpt_ram #(
    .WIDTH (kpt_pkg::VALUE_W),
    .DEPTH (NUM_SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_idx),
    .wdata (req_value),
    .re    (val_re),
    .raddr (match_idx),
    .rdata (val_rdata)
  );

`ifndef SYNTHESIS
  a_full_when_no_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.act && req_cmd == kpt_pkg::CMD_SET && !match_found && !free_found)
    |=> res_status == kpt_pkg::STAT_FULL)
    else $error("set with no match and no free slot did not report full");

  a_remove_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.act && req_cmd == kpt_pkg::CMD_REMOVE && match_found)
    |=> !valid[$past(match_idx)])
    else $error("removed slot still valid");

  a_value_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_value != '0) |-> out_status == kpt_pkg::STAT_OK)
    else $error("non-zero read value with failing status");

  a_set_marks_valid: assert property (@(posedge clk) disable iff (rst)
    set_vld |=> valid[$past(wr_idx)])
    else $error("filled slot not marked valid");
`endif

endmodule

FILE: design/keyed_property_table.sv
// keyed_property_table: top level of a small associative key/value table.
// Uses kpt_pkg; instantiates kpt_ctrl and kpt_datapath (which holds kpt_ram).

// A table of NUM_SLOTS key/value slots serving one request at a time: set
// (update the matching slot or fill the lowest free one, else report full),
// get (value of the matching slot, or zero and not-found) and remove (free the
// matching slot, or not-found). Every request gives exactly one result. A
// request passes through these steps, from its transfer to the loading of its
// result: accept in idle, a scan in which the key RAM is read out and compared
// one slot a cycle, a state for the last compare, one for the update and one
// to load the result register. The scan of the key RAM sets the pace: the
// block takes no new request before the previous one has been through every
// step. A new request is taken as soon as the block is back in idle, even
// while the previous result still waits on the master side; that request's
// result then waits until the register frees, and the block takes nothing
// more meanwhile. Valid bits sit in flip-flops and clear at reset; no
// clearing pass is needed.

module keyed_property_table #(
  parameter int NUM_SLOTS = kpt_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  input  logic [79:0] s_tdata,   // [15:0] key, [79:16] value_in
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic [63:0] m_tdata    // [63:0] read_value
);

  kpt_pkg::ctrl_cmd_t  cmd;
  kpt_pkg::dp_status_t dp_st;

  kpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .dp_st    (dp_st),
    .cmd      (cmd)
  );

  // result register drives the master side directly
  kpt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .dp_st      (dp_st),
    .in_cmd     (s_tuser),
    .in_key     (s_tdata[15:0]),
    .in_value   (s_tdata[79:16]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_value  (m_tdata)
  );

endmodule

FILE: tb/keyed_property_table_test.sv
// keyed_property_table_test: self-checking bench for the keyed property table.
// Depends on kpt_pkg and keyed_property_table; drives both streams and checks
// every result against its own model of the slot table.

module keyed_property_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = kpt_pkg::NUM_SLOTS_DEF;
  localparam int KEY_POOL    = 40;      // more keys than slots, so the table can fill
  localparam int HOLD_CYCLES = 300;     // long result back-pressure stretch
  localparam int CYCLE_LIMIT = 400000;

  // code the block must treat as a no-op
  localparam logic [kpt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic [kpt_pkg::CMD_W-1:0]   cmd_t;
  typedef logic [kpt_pkg::KEY_W-1:0]   key_t;
  typedef logic [kpt_pkg::VALUE_W-1:0] value_t;
  typedef logic [kpt_pkg::STAT_W-1:0]  stat_t;

  typedef struct packed {
    stat_t  status;
    value_t read_value;
  } table_result_t;

  // Shadow copy of the slot table plus the queue of results still owed.
  class prop_table_sb;
    bit            used     [TABLE_SLOTS];
    key_t          key_of   [TABLE_SLOTS];
    value_t        value_of [TABLE_SLOTS];
    table_result_t awaited  [$];
    int            errors;
    int            n_ok;
    int            n_miss;
    int            n_full;
    int            n_got;

    function new();
      foreach (used[i]) begin
        used[i]     = 1'b0;
        key_of[i]   = '0;
        value_of[i] = '0;
      end
    endfunction

    // Apply one accepted request to the shadow table, queue its result.
    function void note_request(cmd_t cmd, key_t key, value_t val);
      int            hit;
      int            free;
      table_result_t r;
      hit  = -1;
      free = -1;
      // walk downwards so the lowest index wins
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
        if (used[i] && key_of[i] == key) hit = i;
        if (!used[i]) free = i;
      end
      r.status     = kpt_pkg::STAT_NOT_FOUND;
      r.read_value = '0;
      case (cmd)
        kpt_pkg::CMD_SET: begin
          if (hit >= 0) begin
            value_of[hit] = val;
            r.status      = kpt_pkg::STAT_OK;
          end else if (free >= 0) begin
            used[free]     = 1'b1;
            key_of[free]   = key;
            value_of[free] = val;
            r.status       = kpt_pkg::STAT_OK;
          end else begin
            r.status = kpt_pkg::STAT_FULL;
          end
        end
        kpt_pkg::CMD_GET: begin
          if (hit >= 0) begin
            r.read_value = value_of[hit];
            r.status     = kpt_pkg::STAT_OK;
          end
        end
        kpt_pkg::CMD_REMOVE: begin
          if (hit >= 0) begin
            used[hit]     = 1'b0;
            key_of[hit]   = '0;
            value_of[hit] = '0;
            r.status      = kpt_pkg::STAT_OK;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(stat_t status, value_t rd);
      table_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d value %h", $time, status, rd);
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
      if (rd !== want.read_value) begin
        errors++;
        $display("%0t: read_value expected %h actual %h", $time, want.read_value, rd);
      end
      case (want.status)
        kpt_pkg::STAT_OK:   n_ok++;
        kpt_pkg::STAT_FULL: n_full++;
        default:            n_miss++;
      endcase
      if (want.status == kpt_pkg::STAT_OK && want.read_value != '0) n_got++;
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser  = '0;   // [1:0] cmd
  logic [79:0] s_tdata  = '0;   // [15:0] key, [79:16] value_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;         // [1:0] status
  logic [63:0] m_tdata;         // [63:0] read_value

  prop_table_sb sb;
  key_t         key_pool [KEY_POOL];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           n_sent = 0;
  int           cycles = 0;

  // hold-off request: toggled by the stimulus, counted down by the receiver
  logic hold_tog  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  keyed_property_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("keyed_property_table_test: errors");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next tready.
  // Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One request transfer. Leaves tvalid high so back-to-back requests
  // need no second assignment in the same step.
  task automatic send_req(cmd_t cmd, key_t key, value_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {val, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(cmd, key, val);
    n_sent++;
  endtask

  // Sender goes quiet until every owed result has arrived.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic value_t rand_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic key_t rand_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
    return key_t'($urandom_range(16'hffff));
  endfunction

  function automatic cmd_t rand_cmd();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return kpt_pkg::CMD_SET;
    if (pick < 75) return kpt_pkg::CMD_GET;
    if (pick < 95) return kpt_pkg::CMD_REMOVE;
    return CMD_UNUSED;
  endfunction

  // Random traffic built from short sequences over the key pool:
  // fill runs push the table to full, clear-outs free slots again,
  // mixed runs churn, and a little noise uses arbitrary keys and codes.
  task automatic run_phase(int items);
    int done;
    int kind;
    int start;
    done = 0;
    while (done < items) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        start = $urandom_range(KEY_POOL - 1);
        for (int i = 0; i < KEY_POOL; i++)
          send_req(kpt_pkg::CMD_SET, key_pool[(start + i) % KEY_POOL], rand_value());
        done += KEY_POOL;
      end else if (kind == 1) begin
        for (int i = 0; i < 20; i++)
          send_req(kpt_pkg::CMD_REMOVE, key_pool[$urandom_range(KEY_POOL - 1)],
                   rand_value());
        done += 20;
      end else if (kind < 9) begin
        for (int i = 0; i < 16; i++) send_req(rand_cmd(), rand_key(), rand_value());
        done += 16;
      end else begin
        for (int i = 0; i < 6; i++)
          send_req(cmd_t'($urandom_range(3)), key_t'($urandom), rand_value());
        done += 6;
      end
    end
  endtask

  initial begin
    sb = new();
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hffff;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = key_t'($urandom_range(16'hffff));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, key extremes, update, remove, unused code.
    send_req(kpt_pkg::CMD_GET,    16'h0000, '0);                     // miss on empty table
    send_req(kpt_pkg::CMD_REMOVE, 16'h0000, '1);                     // remove miss
    send_req(kpt_pkg::CMD_SET,    16'h0000, '0);                     // key zero is ordinary
    send_req(kpt_pkg::CMD_SET,    16'hffff, '1);
    send_req(kpt_pkg::CMD_GET,    16'h0000, '1);
    send_req(kpt_pkg::CMD_GET,    16'hffff, '0);
    send_req(kpt_pkg::CMD_SET,    16'hffff, 64'h0123_4567_89ab_cdef); // update in place
    send_req(kpt_pkg::CMD_GET,    16'hffff, '0);
    send_req(CMD_UNUSED,          16'hffff, '1);                     // no-op, reports miss
    send_req(kpt_pkg::CMD_REMOVE, 16'h0000, '0);
    send_req(kpt_pkg::CMD_GET,    16'h0000, '0);
    send_req(kpt_pkg::CMD_SET,    16'h1234, 64'hfedc_ba98_7654_3210); // reuses lowest free
    send_req(kpt_pkg::CMD_GET,    16'h1234, '0);
    send_req(kpt_pkg::CMD_REMOVE, 16'hffff, '0);
    send_req(kpt_pkg::CMD_REMOVE, 16'hffff, '0);                     // already gone
    send_req(kpt_pkg::CMD_SET,    16'h5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_req(kpt_pkg::CMD_SET,    16'haaaa, 64'h5555_5555_5555_5555);
    send_req(kpt_pkg::CMD_GET,    16'h5555, '0);
    send_req(kpt_pkg::CMD_GET,    16'haaaa, '0);
    send_req(CMD_UNUSED,          16'h0000, '0);

    // Back-pressure: results held off for a long stretch while requests
    // keep coming, so the block fills and stops taking input.
    hold_tog <= ~hold_tog;
    for (int i = 0; i < 10; i++) send_req(rand_cmd(), rand_key(), rand_value());
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  run_phase(205);
    send_idle_pct = 77; recv_stall_pct = 0;  run_phase(205);
    send_idle_pct = 0;  recv_stall_pct = 77; run_phase(205);
    send_idle_pct = 17; recv_stall_pct = 17; run_phase(205);

    drain();
    recv_stall_pct = 0;
    repeat (TABLE_SLOTS + 8) @(posedge clk);

    $display("covered %0d requests: %0d ok, %0d not found, %0d table full",
             n_sent, sb.n_ok, sb.n_miss, sb.n_full);
    $display("%0d gets returned a stored non-zero value; %0d mismatches",
             sb.n_got, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("keyed_property_table_test: clean");
    end else begin
      $display("keyed_property_table_test: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/kpt_pkg.sv
design/kpt_ram.sv
design/kpt_ctrl.sv
design/kpt_datapath.sv
design/keyed_property_table.sv
tb/keyed_property_table_test.sv
